FILE: hw/rtl/lcd_segment_serial_frame_writer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment LCD serial frame writer
// Shared clocking and reset for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef LCD_SEGMENT_SERIAL_FRAME_WRITER_ASSERT_SVH
`define LCD_SEGMENT_SERIAL_FRAME_WRITER_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define LCDSFW_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define LCDSFW_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

FILE: hw/rtl/lcdsfw_pkg.sv
// ----------------------------------------------------------------------------
// lcdsfw_pkg
// Types, codes and helpers shared by the segment LCD frame writer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lcdsfw_pkg;

	// request function codes
	localparam logic [1:0] FUNC_CMD  = 2'd0;
	localparam logic [1:0] FUNC_DATA = 2'd1;
	localparam logic [1:0] FUNC_SEG  = 2'd2;
	localparam logic [1:0] FUNC_NONE = 2'd3;

	// layout codes
	localparam logic [1:0] LAYOUT_PLAIN    = 2'd0;
	localparam logic [1:0] LAYOUT_OFFSET9  = 2'd1;
	localparam logic [1:0] LAYOUT_REVERSED = 2'd2;

	// configuration register indexes
	localparam logic REG_LAYOUT_MODE = 1'b0;
	localparam logic REG_DIGIT_COUNT = 1'b1;

	// frame headers and lengths
	localparam logic [2:0] HDR_CMD  = 3'b100;
	localparam logic [2:0] HDR_DATA = 3'b101;
	localparam int FRAME_LEN_CMD  = 12;
	localparam int FRAME_LEN_DATA = 13;
	localparam int WORD_W         = FRAME_LEN_DATA;
	localparam int BITCNT_W       = $clog2(FRAME_LEN_DATA);
	localparam int SEG_OFFSET     = 9;

	// one decoded request: one or two frames, left aligned in WORD_W bits
	typedef struct packed {
		logic [WORD_W-1:0] word0;
		logic              short0;   // first frame is a 12-bit command
		logic [WORD_W-1:0] word1;
		logic              two;      // a second data frame follows
	} frame_pair_t;

	// reorder segments D,E,F,G (bits 3..6) into nibble D,E,G,F
	function automatic logic [3:0] degf(input logic [7:0] seg);
		return {seg[3], seg[4], seg[6], seg[5]};
	endfunction

	// build a left-aligned data frame word
	function automatic logic [WORD_W-1:0] data_word(input logic [5:0] addr,
			input logic [3:0] nib);
		return {HDR_DATA, addr, nib};
	endfunction

endpackage

FILE: hw/rtl/lcdsfw_front.sv
// ----------------------------------------------------------------------------
// lcdsfw_front
// Holds the layout registers and decodes each request into a frame pair.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdsfw_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [5:0]                cfg_data,
	input  logic                      push,
	input  logic                      q_full,
	input  logic [1:0]                func,
	input  logic [7:0]                command_code,
	input  logic [5:0]                address,
	input  logic [3:0]                nibble,
	input  logic [7:0]                segments,
	input  logic [4:0]                position,
	output logic                      q_wr,
	output lcdsfw_pkg::frame_pair_t   q_wdata
);
	import lcdsfw_pkg::*;

	logic [1:0] layout_mode_q;
	logic [5:0] digit_count_q;
	logic [5:0] addr_lo;
	logic [4:0] rev_pos;

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_mode_q <= LAYOUT_PLAIN;
			digit_count_q <= 6'd6;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LAYOUT_MODE: layout_mode_q <= cfg_data[1:0];
				REG_DIGIT_COUNT: digit_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// derived addresses: segment address kept to 6 bits, reversed position to 5 bits
	assign addr_lo = 6'(SEG_OFFSET) + {position, 1'b0};
	assign rev_pos = 5'(digit_count_q - {1'b0, position} - 6'd1);

	// decode the request
	always_comb begin
		q_wdata = '0;
		unique case (func)
			FUNC_CMD: begin
				q_wdata.word0  = {HDR_CMD, command_code, 2'b00};
				q_wdata.short0 = 1'b1;
			end
			FUNC_DATA: begin
				q_wdata.word0 = data_word(address, nibble);
			end
			FUNC_SEG: begin
				q_wdata.two = 1'b1;
				unique case (layout_mode_q)
					LAYOUT_OFFSET9: begin
						q_wdata.word0 = data_word(addr_lo, degf(segments));
						q_wdata.word1 = data_word(addr_lo + 6'd1, {1'b0, segments[2:0]});
					end
					LAYOUT_REVERSED: begin
						q_wdata.word0 = data_word({rev_pos, 1'b0},
							{segments[7], segments[2:0]});
						q_wdata.word1 = data_word({rev_pos, 1'b1}, degf(segments));
					end
					default: begin
						q_wdata.word0 = data_word({position, 1'b0}, segments[3:0]);
						q_wdata.word1 = data_word({position, 1'b1}, segments[7:4]);
					end
				endcase
			end
			default: ;
		endcase
	end

	// enqueue everything but the unused function code
	assign q_wr = push && !q_full && (func != FUNC_NONE);

endmodule

FILE: hw/rtl/lcdsfw_fifo.sv
// ----------------------------------------------------------------------------
// lcdsfw_fifo
// Short register queue of decoded frame pairs between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdsfw_fifo #(
	parameter int DEPTH = 2
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  lcdsfw_pkg::frame_pair_t   wdata,
	input  logic                      rd_en,
	output lcdsfw_pkg::frame_pair_t   rdata,
	output logic                      full,
	output logic                      not_empty
);
	import lcdsfw_pkg::*;

	`include "lcd_segment_serial_frame_writer_assert.svh"

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_pair_t        mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	// store the incoming beat
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign rdata     = mem_q[rd_ptr_q];
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign not_empty = (cnt_q != '0);

	`LCDSFW_NEVER(a_fifo_overflow, cnt_q > CNT_W'(DEPTH), "queue count above depth")
	`LCDSFW_NEVER(a_fifo_underrun, rd_en && (cnt_q == '0), "read from empty queue")
	`LCDSFW_NEVER(a_fifo_write_full, wr_en && full && !rd_en, "write into full queue")

endmodule

FILE: hw/rtl/lcdsfw_back.sv
// ----------------------------------------------------------------------------
// lcdsfw_back
// Serializes frame pairs, one wire bit per output beat, MSB first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcdsfw_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lcdsfw_pkg::frame_pair_t   q_rdata,
	input  logic                      q_valid,
	output logic                      q_rd,
	input  logic                      pop,
	output logic                      empty,
	output logic                      data_bit,
	output logic                      frame_start,
	output logic                      frame_end,
	output logic                      last
);
	import lcdsfw_pkg::*;

	`include "lcd_segment_serial_frame_writer_assert.svh"

	logic                active_q;
	logic [WORD_W-1:0]   shift_q;
	logic [BITCNT_W-1:0] cnt_q;
	logic                short_q;
	logic                more_q;
	logic [WORD_W-1:0]   next_q;

	logic                ovalid_q;
	logic                data_bit_q;
	logic                frame_start_q;
	logic                frame_end_q;
	logic                last_q;

	logic                advance;
	logic                emit;
	logic [WORD_W-1:0]   src_word;
	logic [BITCNT_W-1:0] src_cnt;
	logic                src_short;
	logic                src_more;
	logic                bit_end;

	// pick the bit source: the frame in progress or the queue head
	always_comb begin
		if (active_q) begin
			src_word  = shift_q;
			src_cnt   = cnt_q;
			src_short = short_q;
			src_more  = more_q;
		end else begin
			src_word  = q_rdata.word0;
			src_cnt   = '0;
			src_short = q_rdata.short0;
			src_more  = q_rdata.two;
		end
	end

	assign advance = !ovalid_q || pop;
	assign emit    = advance && (active_q || q_valid);
	assign q_rd    = emit && !active_q;
	assign bit_end = src_short ? (src_cnt == BITCNT_W'(FRAME_LEN_CMD - 1))
	                           : (src_cnt == BITCNT_W'(FRAME_LEN_DATA - 1));

	// step the serializer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			short_q  <= 1'b0;
			more_q   <= 1'b0;
		end else if (emit) begin
			if (bit_end) begin
				active_q <= src_more;
				cnt_q    <= '0;
				short_q  <= 1'b0;
				more_q   <= 1'b0;
			end else begin
				active_q <= 1'b1;
				cnt_q    <= src_cnt + 1'b1;
				short_q  <= src_short;
				more_q   <= src_more;
			end
		end
	end

	// shift data and hold the second frame
	always_ff @(posedge clk) begin
		if (q_rd) begin
			next_q <= q_rdata.word1;
		end
		if (emit) begin
			shift_q <= bit_end ? (active_q ? next_q : q_rdata.word1) : (src_word << 1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (advance) begin
			ovalid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			data_bit_q    <= src_word[WORD_W-1];
			frame_start_q <= (src_cnt == '0);
			frame_end_q   <= bit_end;
			last_q        <= bit_end && !src_more;
		end
	end

	assign empty       = !ovalid_q;
	assign data_bit    = data_bit_q;
	assign frame_start = frame_start_q;
	assign frame_end   = frame_end_q;
	assign last        = last_q;

	`LCDSFW_ASSERT(a_last_ends_frame, (ovalid_q && last_q) |-> frame_end_q, "last off a frame end")
	`LCDSFW_ASSERT(a_second_frame, (emit && bit_end && src_more) |=> active_q, "second frame lost")
	`LCDSFW_NEVER(a_cnt_range, active_q && (cnt_q > BITCNT_W'(FRAME_LEN_DATA - 1)), "bit count range")

endmodule

FILE: hw/rtl/lcd_segment_serial_frame_writer.sv
// ----------------------------------------------------------------------------
// lcd_segment_serial_frame_writer
// Turns command, data and segment requests into serial LCD frame bits.
// ----------------------------------------------------------------------------
// Requests enter through a queue-like port: a beat is taken when push is high
// and full is low. Commands give one 12-bit frame, raw data writes one 13-bit
// frame, segment writes two 13-bit frames; unused function codes are dropped.
// Results leave one wire bit per beat: the oldest bit sits on the ports while
// empty is low and is taken when pop is high.
// A taken request is written into the queue, read from it by the serializer,
// and its first bit is loaded into the output register. Throughput: one bit
// per cycle while pop or empty is high, set by the single bit serializer in
// the back end. A queue of FIFO_DEPTH decoded requests lets the front keep
// accepting meanwhile. When pop stays low the output register holds its bit,
// the serializer stops, and full rises once the queue fills.
// Reset clears the queue and output; layout_mode returns to 0 and
// digit_count to 6. Write configuration only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lcd_segment_serial_frame_writer #(
	parameter int FIFO_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [5:0] cfg_data,
	input  logic       push,
	output logic       full,
	input  logic [1:0] func,
	input  logic [7:0] command_code,
	input  logic [5:0] address,
	input  logic [3:0] nibble,
	input  logic [7:0] segments,
	input  logic [4:0] position,
	output logic       empty,
	input  logic       pop,
	output logic       data_bit,
	output logic       frame_start,
	output logic       frame_end,
	output logic       last
);
	import lcdsfw_pkg::*;

	frame_pair_t q_wdata;
	frame_pair_t q_rdata;
	logic        q_wr;
	logic        q_rd;
	logic        q_valid;

	// decode requests
	lcdsfw_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (push),
		.q_full       (full),
		.func         (func),
		.command_code (command_code),
		.address      (address),
		.nibble       (nibble),
		.segments     (segments),
		.position     (position),
		.q_wr         (q_wr),
		.q_wdata      (q_wdata)
	);

	// buffer decoded requests
	lcdsfw_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (q_wr),
		.wdata     (q_wdata),
		.rd_en     (q_rd),
		.rdata     (q_rdata),
		.full      (full),
		.not_empty (q_valid)
	);

	// serialize frames
	lcdsfw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_rdata     (q_rdata),
		.q_valid     (q_valid),
		.q_rd        (q_rd),
		.pop         (pop),
		.empty       (empty),
		.data_bit    (data_bit),
		.frame_start (frame_start),
		.frame_end   (frame_end),
		.last        (last)
	);

endmodule
